@@ rtl/sfh_pkg.sv @@
package sfh_pkg;

    localparam int QUEUE_DEPTH = 4;

    // one classified key word, handed from the front part to the back part
    typedef struct packed {
        logic        load;      // restart running hash with seed
        logic [15:0] seed;
        logic        mix;       // a 4-byte group is complete
        logic [15:0] lo_half;
        logic [15:0] hi_half;
        logic        fin;       // last word of the key
        logic [1:0]  phase;     // tail bytes held at the end
        logic [15:0] tail_w0;
        logic [7:0]  tail_b2;
        logic        mism;
    } sfh_op_t;

endpackage

@@ rtl/sfh_front.sv @@
module sfh_front
    import sfh_pkg::*;
#(
    parameter longint unsigned MAX_KEY_BYTES = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        first,
    input  logic        last,
    input  logic [15:0] key_length,
    output sfh_op_t     op
);

    localparam int CNT_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEY_BYTES);

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             over_reg, over_next;
    logic [15:0]      stated_reg, stated_next;
    logic             fresh_reg, fresh_next;
    logic [7:0]       pend_reg [3];
    logic [7:0]       pend_next [3];

    logic             take;
    logic [1:0]       base_phase;
    logic [CNT_W-1:0] base_cnt;
    logic             base_over;
    logic [15:0]      base_stated;
    logic [1:0]       upd_phase;
    logic [CNT_W-1:0] upd_cnt;
    logic             upd_over;

    always_comb
    begin
        take        = !(first && (key_length == 16'd0));
        base_phase  = first ? 2'd0 : phase_reg;
        base_cnt    = first ? '0 : cnt_reg;
        base_over   = first ? 1'b0 : over_reg;
        base_stated = first ? key_length : stated_reg;

        upd_phase    = base_phase;
        upd_cnt      = base_cnt;
        upd_over     = base_over;
        pend_next[0] = pend_reg[0];
        pend_next[1] = pend_reg[1];
        pend_next[2] = pend_reg[2];

        op         = '0;
        op.load    = first || fresh_reg;
        op.seed    = first ? key_length : 16'd0;
        op.lo_half = {pend_reg[1], pend_reg[0]};
        op.hi_half = {data_byte, pend_reg[2]};

        if (take)
        begin
            if (base_cnt >= CNT_MAX)
            begin
                upd_over = 1'b1;
            end
            else
            begin
                upd_cnt = base_cnt + 1'b1;
            end
            if (base_phase == 2'd3)
            begin
                op.mix    = 1'b1;
                upd_phase = 2'd0;
            end
            else
            begin
                pend_next[base_phase] = data_byte;
                upd_phase             = base_phase + 2'd1;
            end
        end

        op.fin     = last;
        op.phase   = upd_phase;
        op.tail_w0 = {pend_next[1], pend_next[0]};
        op.tail_b2 = pend_next[2];
        op.mism    = upd_over || (CMP_W'(upd_cnt) != CMP_W'(base_stated));

        // a finished key returns the state to its cleared values
        if (last)
        begin
            phase_next  = 2'd0;
            cnt_next    = '0;
            over_next   = 1'b0;
            stated_next = 16'd0;
            fresh_next  = 1'b1;
        end
        else
        begin
            phase_next  = upd_phase;
            cnt_next    = upd_cnt;
            over_next   = upd_over;
            stated_next = base_stated;
            fresh_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 2'd0;
            cnt_reg    <= '0;
            over_reg   <= 1'b0;
            stated_reg <= 16'd0;
            fresh_reg  <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            over_reg   <= over_next;
            stated_reg <= stated_next;
            fresh_reg  <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg[0] <= pend_next[0];
            pend_reg[1] <= pend_next[1];
            pend_reg[2] <= pend_next[2];
        end
    end

endmodule

@@ rtl/sfh_queue.sv @@
module sfh_queue
    import sfh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  sfh_op_t push_op,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output sfh_op_t head_op
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sfh_op_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ rtl/sfh_back.sv @@
module sfh_back
    import sfh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  sfh_op_t     op,
    output logic        op_pop,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [31:0] res_hash,
    output logic        res_mism
);

    function automatic logic [31:0] mix_group(input logic [31:0] h_in,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
        logic [31:0] h;
        logic [31:0] t;
        h = h_in + {16'd0, lo};
        t = ({16'd0, hi} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [31:0] mix_tail(input logic [31:0] h_in,
                                             input logic [1:0]  phase,
                                             input logic [15:0] w0,
                                             input logic [7:0]  b2);
        logic [31:0] h;
        h = h_in;
        case (phase)
            2'd3:
            begin
                h = h + {16'd0, w0};
                h = h ^ (h << 16);
                h = h ^ ({{24{b2[7]}}, b2} << 18);
                h = h + (h >> 11);
            end
            2'd2:
            begin
                h = h + {16'd0, w0};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1:
            begin
                // single tail byte is sign-extended
                h = h + {{24{w0[7]}}, w0[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in;
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    logic [31:0] hash_reg;
    logic [31:0] h_base, h_mix;

    // tail stage
    logic        b_valid_reg;
    logic [31:0] b_hash_reg;
    logic [1:0]  b_phase_reg;
    logic [15:0] b_w0_reg;
    logic [7:0]  b_b2_reg;
    logic        b_mism_reg;

    // avalanche stage
    logic        c_valid_reg;
    logic [31:0] c_hash_reg;
    logic        c_mism_reg;

    // result word
    logic        out_valid_reg;
    logic [31:0] out_hash_reg;
    logic        out_mism_reg;

    logic out_load, c_ready, b_move, b_ready;

    assign out_load = c_valid_reg && (!out_valid_reg || res_ready);
    assign c_ready  = !c_valid_reg || out_load;
    assign b_move   = b_valid_reg && c_ready;
    assign b_ready  = !b_valid_reg || b_move;
    assign op_pop   = op_valid && b_ready;

    assign h_base = op.load ? {16'd0, op.seed} : hash_reg;
    assign h_mix  = op.mix ? mix_group(h_base, op.lo_half, op.hi_half) : h_base;

    assign res_valid = out_valid_reg;
    assign res_hash  = out_hash_reg;
    assign res_mism  = out_mism_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= 32'd0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_pop)
            begin
                hash_reg <= op.fin ? 32'd0 : h_mix;
            end
            if (op_pop && op.fin)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_move)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_move)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                c_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop && op.fin)
        begin
            b_hash_reg  <= h_mix;
            b_phase_reg <= op.phase;
            b_w0_reg    <= op.tail_w0;
            b_b2_reg    <= op.tail_b2;
            b_mism_reg  <= op.mism;
        end
        if (b_move)
        begin
            c_hash_reg <= mix_tail(b_hash_reg, b_phase_reg, b_w0_reg, b_b2_reg);
            c_mism_reg <= b_mism_reg;
        end
        if (out_load)
        begin
            out_hash_reg <= avalanche(c_hash_reg);
            out_mism_reg <= c_mism_reg;
        end
    end

endmodule

@@ rtl/superfasthash_stream_unit.sv @@
// channel | signals                         | contents
// s       | s_tvalid s_tready s_tdata s_tlast s_tuser | key byte, length, first/last marks
// m       | m_tvalid m_tready m_tdata m_tuser | finished hash and length mismatch flag
//
// one word per cycle is taken while the queue is not full; each key's last word passes
// through the queue, group mix into tail stage, tail mix, avalanche into the output
// register; the front keeps byte gathering and counting, the back the hash
// a 4-entry queue between them takes up to four more words while the result side stalls
// reset clears all control state and the running hash; no clearing pass is needed
module superfasthash_stream_unit
    import sfh_pkg::*;
#(
    parameter longint unsigned MAX_KEY_BYTES = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], key_length[23:8]
    input  logic        s_tlast,   // last
    input  logic [0:0]  s_tuser,   // first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // hash_value[31:0]
    output logic [0:0]  m_tuser    // length_mismatch
);

    logic    accept;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    sfh_op_t front_op;
    sfh_op_t head_op;
    logic    res_mism;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    sfh_front #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata[7:0]),
        .first      (s_tuser[0]),
        .last       (s_tlast),
        .key_length (s_tdata[23:8]),
        .op         (front_op)
    );

    sfh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_op   (front_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    sfh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_not_empty),
        .op        (head_op),
        .op_pop    (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_hash  (m_tdata),
        .res_mism  (res_mism)
    );

    assign m_tuser = res_mism;

endmodule

@@ tb/sv/tb.sv @@
module tb;

    localparam int unsigned MAX_KEY_BYTES  = 65535;
    localparam int          RANDOM_WORDS   = 1560;
    localparam int          CALM_AFTER     = 1360;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 20;

    typedef struct packed {
        logic [31:0] hash;
        logic        mism;
    } digest_t;

    typedef struct packed {
        logic [7:0]  kbyte;
        logic        head;
        logic        tail;
        logic [15:0] klen;
        logic        fixed;   // expected digest typed in below
        logic [31:0] hash;
        logic        mism;
    } plan_row_t;

    localparam plan_row_t PLAN [26] = '{
        // empty keys: the byte is dropped and the hash is zero
        '{8'hFF, 1'b1, 1'b1, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{8'h00, 1'b1, 1'b1, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        // one-byte tails, negative and positive, then two- and three-byte tails
        '{8'h80, 1'b1, 1'b1, 16'h0001, 1'b0, 32'h0, 1'b0},
        '{8'h7F, 1'b1, 1'b1, 16'h0001, 1'b0, 32'h0, 1'b0},
        '{8'hFF, 1'b1, 1'b0, 16'h0002, 1'b0, 32'h0, 1'b0},
        '{8'h01, 1'b0, 1'b1, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{8'h12, 1'b1, 1'b0, 16'h0003, 1'b0, 32'h0, 1'b0},
        '{8'h34, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0, 1'b0},
        // one full group, no tail
        '{8'hFF, 1'b1, 1'b0, 16'h0004, 1'b0, 32'h0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        // stated length far off
        '{8'h00, 1'b1, 1'b0, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{8'hAA, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0, 1'b0},
        // bytes with no leading word
        '{8'h55, 1'b0, 1'b0, 16'h1234, 1'b0, 32'h0, 1'b0},
        '{8'hC3, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0, 1'b0},
        // zero length stated, then a byte follows anyway
        '{8'h5A, 1'b1, 1'b0, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{8'h11, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0, 1'b0},
        // key restarted before its end
        '{8'h01, 1'b1, 1'b0, 16'h0005, 1'b0, 32'h0, 1'b0},
        '{8'h02, 1'b1, 1'b1, 16'h0001, 1'b0, 32'h0, 1'b0},
        // group mix followed by a one-byte tail
        '{8'h00, 1'b1, 1'b0, 16'h0005, 1'b0, 32'h0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{8'h01, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // data_byte[7:0], key_length[23:8]
    logic        s_tlast;   // last
    logic [0:0]  s_tuser;   // first
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // hash_value[31:0]
    logic [0:0]  m_tuser;   // length_mismatch

    // travels with the word being offered
    logic        row_fixed;
    logic [31:0] row_hash;
    logic        row_mism;

    bit          idle_on;
    bit          hold_rx;
    int          errors;
    int          stall_cycles;
    int          random_words;

    // predictor state
    logic [31:0] run_hash;
    logic [7:0]  held [3];
    logic [1:0]  held_n;
    int unsigned byte_cnt;
    logic [15:0] length_said;
    bit          overflowed;

    digest_t     digest_q [$];
    digest_t     want;
    digest_t     made;
    bit          produced;

    superfasthash_stream_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void hash_clear();
        run_hash    = 32'd0;
        held[0]     = 8'd0;
        held[1]     = 8'd0;
        held[2]     = 8'd0;
        held_n      = 2'd0;
        byte_cnt    = 0;
        length_said = 16'd0;
        overflowed  = 1'b0;
    endfunction

    function automatic logic [31:0] hash_close();
        logic [31:0] h;
        logic [31:0] w0;
        h  = run_hash;
        w0 = {16'd0, held[1], held[0]};
        case (held_n)
            2'd3:
            begin
                h = h + w0;
                h = h ^ (h << 16);
                h = h ^ ({{24{held[2][7]}}, held[2]} << 18);
                h = h + (h >> 11);
            end
            2'd2:
            begin
                h = h + w0;
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1:
            begin
                h = h + {{24{held[0][7]}}, held[0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
            end
        endcase
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    function automatic void hash_absorb(input logic [7:0] kbyte, input logic head,
                                        input logic tail, input logic [15:0] klen,
                                        output bit done, output digest_t res);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] t;
        bit          take;
        take = 1'b1;
        done = 1'b0;
        res  = '0;
        if (head)
        begin
            hash_clear();
            run_hash    = {16'd0, klen};
            length_said = klen;
            if (klen == 16'd0)
                take = 1'b0;
        end
        if (take)
        begin
            if (byte_cnt >= MAX_KEY_BYTES)
                overflowed = 1'b1;
            else
                byte_cnt++;
            if (held_n != 2'd3)
            begin
                held[held_n] = kbyte;
                held_n       = held_n + 2'd1;
            end
            else
            begin
                lo       = {16'd0, held[1], held[0]};
                hi       = {16'd0, kbyte, held[2]};
                run_hash = run_hash + lo;
                t        = (hi << 11) ^ run_hash;
                run_hash = (run_hash << 16) ^ t;
                run_hash = run_hash + (run_hash >> 11);
                held_n   = 2'd0;
            end
        end
        if (tail)
        begin
            res.hash = hash_close();
            res.mism = overflowed || (byte_cnt != {16'd0, length_said});
            done     = 1'b1;
            hash_clear();
        end
    endfunction

    function automatic void flag_error(input string what, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
        errors++;
        if (errors <= 10)
            $display("mismatch on %s: expected %h, got %h", what, exp_v, act_v);
    endfunction

    // checks results, predicts from accepted words, and watches for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                    flag_error("unexpected result", 32'd0, m_tdata);
                else
                begin
                    want = digest_q.pop_front();
                    if (m_tdata !== want.hash)
                        flag_error("hash_value", want.hash, m_tdata);
                    if (m_tuser[0] !== want.mism)
                        flag_error("length_mismatch", {31'd0, want.mism}, {31'd0, m_tuser[0]});
                end
            end
            if (s_tvalid && s_tready)
            begin
                hash_absorb(s_tdata[7:0], s_tuser[0], s_tlast, s_tdata[23:8], produced, made);
                if (produced)
                    digest_q.push_back(row_fixed ? {row_hash, row_mism} : made);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_word(input logic [7:0] kbyte, input logic head, input logic tail,
                             input logic [15:0] klen, input logic fixed = 1'b0,
                             input logic [31:0] hash = 32'd0, input logic mism = 1'b0);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {klen, kbyte};
        s_tlast   <= tail;
        s_tuser   <= head;
        row_fixed <= fixed;
        row_hash  <= hash;
        row_mism  <= mism;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_key(input int n, input logic [15:0] said, input bit lead,
                            input bit finish);
        for (int i = 0; i < n; i++)
            send_word(8'($urandom_range(0, 255)), lead && i == 0, finish && i == n - 1,
                      (lead && i == 0) ? said : 16'($urandom));
    endtask

    task automatic random_key();
        int          n;
        int          kind;
        logic [15:0] said;
        kind = $urandom_range(0, 19);
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        said = 16'(n);
        if (n == 0 && kind > 5)
        begin
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1, 16'd0);
            random_words++;
            return;
        end
        if (n == 0)
            n = 1;
        if (kind == 3)
            n = $urandom_range(1, 4);
        case (kind)
            0: send_key(n, 16'($urandom), 1'b1, 1'b1);
            1: send_key(n, ($urandom_range(0, 1) != 0) ? said + 16'd1 : said - 16'd1, 1'b1, 1'b1);
            2: send_key(n, said, 1'b0, 1'b1);
            3: send_key(n, 16'($urandom), 1'($urandom_range(0, 1)), 1'b0);
            4: send_key(n, said, 1'b1, 1'b0);
            5:
            begin
                // zero length stated, bytes keep coming
                send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, 16'd0);
                send_key(n, said, 1'b0, 1'b1);
                random_words++;
            end
            default: send_key(n, said, 1'b1, 1'b1);
        endcase
        random_words += n;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = '0;
        row_fixed = 1'b0;
        row_hash  = '0;
        row_mism  = 1'b0;
        idle_on   = 1'b1;
        hold_rx   = 1'b0;
        errors    = 0;
        stall_cycles = 0;
        random_words = 0;
        hash_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
            send_word(PLAN[i].kbyte, PLAN[i].head, PLAN[i].tail, PLAN[i].klen,
                      PLAN[i].fixed, PLAN[i].hash, PLAN[i].mism);
        drain();

        // short keys pile up behind a stalled result side
        hold_rx = 1'b1;
        repeat (60)
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1, 16'd1);
        drain();

        while (random_words < RANDOM_WORDS)
        begin
            if (random_words >= CALM_AFTER)
                idle_on = 1'b0;
            random_key();
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
